/* hdl/gehr_pkg.sv */
// Shared constants, codes and control structs of the extremum hop radius engine.
`timescale 1ns / 1ps
package gehr_pkg;

  // Graph storage geometry and widths (NV and ND are powers of two).
  localparam int NV    = 1024;
  localparam int VW    = 10;
  localparam int CW    = 11;
  localparam int ND    = 16;
  localparam int DW    = 4;
  localparam int DGW   = 5;
  localparam int VALW  = 32;
  localparam int WTW   = 16;
  localparam int SUMW  = 26;
  localparam int THRW  = 17;
  localparam int HOPW  = 10;
  localparam int RADW  = 11;
  localparam int FRACW = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_THR   = 2'd0;
  localparam logic [1:0] REG_SEEK  = 2'd1;
  localparam logic [1:0] REG_HOPS  = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_LINK  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RS_ZERO = 2'd0,
    RS_NEG  = 2'd1,
    RS_LAST = 2'd2
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    clr_start;
    logic    clr_step;
    logic    load_vertex;
    logic    deg_rd;
    logic    deg_cap;
    logic    nb_add;
    logic    yv_rd;
    logic    yv_cap;
    logic    scan_start;
    logic    scan_step;
    logic    nb_rd;
    logic    nb_cap;
    logic    d_inc;
    logic    vw_rd;
    logic    visit;
    logic    bfs_init;
    logic    lvl_start;
    logic    q_rd;
    logic    q_cap;
    logic    lvl_end;
    logic    lvl_accept;
    logic    res_set;
    status_t res_status;
    res_t    res_sel;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  idx_bad;
    logic  deg_full;
    logic  clr_last;
    logic  scan_last;
    logic  is_ext;
    logic  d_end;
    logic  nb_bad;
    logic  worse;
    logic  visited;
    logic  lvl_stop;
    logic  i_end;
    logic  tot_zero;
    logic  share_ok;
    logic  out_free;
  } sts_t;

endpackage

/* hdl/graph_extremum_hop_radius.sv */
// Top level of the graph local-extremum hop radius engine.
// A query runs the value scan and the extremum test, then tests each neighbor slot
// (a stale one is skipped), then walks the graph level by level.
// One item is in work at a time; a result waits in the output register.
// Reset (synchronous, active low) starts a degree clearing pass.
`timescale 1ns / 1ps
module graph_extremum_hop_radius import gehr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [71:0] in_tdata,   // vertex_index, neighbor_index, sample_value, weight
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // radius, status
);

  cmd_t cmd;
  sts_t sts;

  gehr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gehr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* hdl/gehr_ctrl.sv */
// Controller state machine that sequences loads, links, clearing passes and queries.
`timescale 1ns / 1ps
module gehr_ctrl import gehr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_EXEC  = 19'h00004,
    S_ADDW  = 19'h00008,
    S_ADD   = 19'h00010,
    S_YV    = 19'h00020,
    S_SCAN  = 19'h00040,
    S_SCANE = 19'h00080,
    S_EXT   = 19'h00100,
    S_DEGW  = 19'h00200,
    S_NB    = 19'h00400,
    S_NBW   = 19'h00800,
    S_CHK   = 19'h01000,
    S_VW    = 19'h02000,
    S_LVL   = 19'h04000,
    S_QRD   = 19'h08000,
    S_QW    = 19'h10000,
    S_DRD   = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   item_r, item_nxt;   // clearing pass was requested by an item
  logic   bfs_r, bfs_nxt;     // edge loop runs the walk, not the neighbor test
  logic   cmp_r, cmp_nxt;     // level product registered, compare pending

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    bfs_nxt   = bfs_r;
    cmp_nxt   = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (item_r) begin
            cmd.res_set = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.mode == MODE_CLEAR) begin
          cmd.clr_start = 1'b1;
          item_nxt      = 1'b1;
          state_nxt     = S_CLR;
        end else if (sts.idx_bad) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_RANGE;
          state_nxt      = S_OUT;
        end else if (sts.mode == MODE_LOAD) begin
          cmd.load_vertex = 1'b1;
          cmd.res_set     = 1'b1;
          state_nxt       = S_OUT;
        end else if (sts.mode == MODE_LINK) begin
          cmd.deg_rd = 1'b1;
          state_nxt  = S_ADDW;
        end else begin
          cmd.yv_rd = 1'b1;
          state_nxt = S_YV;
        end
      end
      S_ADDW: begin
        cmd.deg_cap = 1'b1;
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        cmd.res_set = 1'b1;
        if (sts.deg_full) begin
          cmd.res_status = ST_FULL;
        end else begin
          cmd.nb_add = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_YV: begin
        cmd.yv_cap     = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCANE;
        end
      end
      S_SCANE: begin
        state_nxt = S_EXT;
      end
      S_EXT: begin
        if (sts.is_ext) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RS_NEG;
          state_nxt   = S_OUT;
        end else begin
          cmd.deg_rd = 1'b1;
          bfs_nxt    = 1'b0;
          state_nxt  = S_DEGW;
        end
      end
      S_DEGW: begin
        cmd.deg_cap = 1'b1;
        state_nxt   = S_NB;
      end
      S_NB: begin
        if (sts.d_end) begin
          if (!bfs_r) begin
            cmd.bfs_init = 1'b1;
            bfs_nxt      = 1'b1;
            state_nxt    = S_LVL;
          end else begin
            state_nxt = S_QRD;
          end
        end else begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NBW;
        end
      end
      S_NBW: begin
        cmd.nb_cap = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (sts.nb_bad) begin
          cmd.d_inc = 1'b1;
          state_nxt = S_NB;
        end else begin
          cmd.vw_rd = 1'b1;
          state_nxt = S_VW;
        end
      end
      S_VW: begin
        if (!bfs_r && !sts.worse) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.visit = bfs_r && !sts.visited;
          cmd.d_inc = 1'b1;
          state_nxt = S_NB;
        end
      end
      S_LVL: begin
        if (cmp_r) begin
          // Level finished: stop on empty total or a share below threshold.
          if (sts.tot_zero || !sts.share_ok) begin
            cmd.res_set = 1'b1;
            cmd.res_sel = RS_LAST;
            state_nxt   = S_OUT;
          end else begin
            cmd.lvl_accept = 1'b1;
          end
        end else if (sts.lvl_stop) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RS_LAST;
          state_nxt   = S_OUT;
        end else begin
          cmd.lvl_start = 1'b1;
          state_nxt     = S_QRD;
        end
      end
      S_QRD: begin
        if (sts.i_end) begin
          cmd.lvl_end = 1'b1;
          cmp_nxt     = 1'b1;
          state_nxt   = S_LVL;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = S_QW;
        end
      end
      S_QW: begin
        cmd.q_cap = 1'b1;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        cmd.deg_rd = 1'b1;
        state_nxt  = S_DEGW;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers; reset starts the degree clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      item_r  <= 1'b0;
      bfs_r   <= 1'b0;
      cmp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      item_r  <= item_nxt;
      bfs_r   <= bfs_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

endmodule

/* hdl/gehr_dp.sv */
// Datapath: configuration, graph memories, level queues, sums and result registers.
`timescale 1ns / 1ps
module gehr_dp import gehr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [THRW-1:0] cfg_wdata,
  input  logic [1:0]      in_tuser,
  input  logic [71:0]     in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  input  cmd_t            cmd,
  output sts_t            sts
);

  // Configuration registers.
  logic [THRW-1:0] thr_r;
  logic            seek_r;
  logic [HOPW-1:0] hop_limit_r;
  logic [CW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRW'(65536);
      seek_r      <= 1'b1;
      hop_limit_r <= HOPW'(8);
      count_r     <= CW'(NV);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THR:   thr_r       <= cfg_wdata;
        REG_SEEK:  seek_r      <= cfg_wdata[0];
        REG_HOPS:  hop_limit_r <= cfg_wdata[HOPW-1:0];
        REG_COUNT: count_r     <= cfg_wdata[CW-1:0];
        default:   ;
      endcase
    end
  end

  logic [CW-1:0] n_w;
  assign n_w = (count_r > CW'(NV)) ? CW'(NV) : count_r;

  // Latched input item.
  mode_t                  mode_r;
  logic [VW-1:0]          vi_r, nbi_r;
  logic signed [VALW-1:0] samp_r;
  logic [WTW-1:0]         wt_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_tuser);
      vi_r   <= in_tdata[9:0];
      nbi_r  <= in_tdata[19:10];
      samp_r <= in_tdata[51:20];
      wt_r   <= in_tdata[67:52];
    end
  end

  // Walk registers.
  logic [VW-1:0]          cv_r, nbv_r;
  logic [DGW-1:0]         deg_r, d_r;
  logic [CW-1:0]          cnt_r, i_r, cur_len_r, next_len_r;
  logic                   scan_vld_r, first_r, bank_r;
  logic signed [VALW-1:0] yv_r, gmin_r, gmax_r;
  logic [SUMW-1:0]        tot_r, sat_r;
  logic [HOPW-1:0]        hop_r, last_ok_r;
  logic [THRW+SUMW-1:0]   prod_r;

  // Memories and their registered read data.
  logic [DGW-1:0]  deg_mem [NV];
  logic [VW-1:0]   nb_mem  [NV*ND];
  logic [VALW-1:0] val_mem [NV];
  logic [WTW-1:0]  wt_mem  [NV];
  logic            vis_mem [NV];
  logic [VW-1:0]   q_mem   [2*NV];

  logic [DGW-1:0]         deg_q;
  logic [VW-1:0]          nb_q, q_q;
  logic signed [VALW-1:0] val_q;
  logic [WTW-1:0]         wt_q;
  logic                   vis_q;
  logic [VW-1:0]          val_addr;

  // Degree store: cleared by sweeps, bumped on neighbor appends.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      deg_mem[cnt_r[VW-1:0]] <= '0;
    end else if (cmd.nb_add) begin
      deg_mem[cv_r] <= deg_r + DGW'(1);
    end
    if (cmd.deg_rd) begin
      deg_q <= deg_mem[cv_r];
    end
  end

  // Neighbor slots, addressed by vertex and slot.
  always_ff @(posedge clk) begin
    if (cmd.nb_add) begin
      nb_mem[{cv_r, deg_r[DW-1:0]}] <= nbi_r;
    end
    if (cmd.nb_rd) begin
      nb_q <= nb_mem[{cv_r, d_r[DW-1:0]}];
    end
  end

  // Value and weight stores share one read address.
  always_comb begin
    if (cmd.yv_rd) begin
      val_addr = vi_r;
    end else if (cmd.scan_step) begin
      val_addr = cnt_r[VW-1:0];
    end else begin
      val_addr = nbv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vertex) begin
      val_mem[vi_r] <= samp_r;
      wt_mem[vi_r]  <= wt_r;
    end
    if (cmd.yv_rd || cmd.scan_step || cmd.vw_rd) begin
      val_q <= val_mem[val_addr];
      wt_q  <= wt_mem[val_addr];
    end
  end

  // Visited marks: cleared during the value scan, set by the walk.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      vis_mem[cnt_r[VW-1:0]] <= 1'b0;
    end else if (cmd.visit) begin
      vis_mem[nbv_r] <= 1'b1;
    end else if (cmd.bfs_init) begin
      vis_mem[vi_r] <= 1'b1;
    end
    if (cmd.vw_rd) begin
      vis_q <= vis_mem[nbv_r];
    end
  end

  // Level queues: two banks, the current level is read from bank_r.
  always_ff @(posedge clk) begin
    if (cmd.visit) begin
      q_mem[{~bank_r, next_len_r[VW-1:0]}] <= nbv_r;
    end else if (cmd.bfs_init) begin
      q_mem[{1'b0, {VW{1'b0}}}] <= vi_r;
    end
    if (cmd.q_rd) begin
      q_q <= q_mem[{bank_r, i_r[VW-1:0]}];
    end
  end

  logic worse_w;
  assign worse_w = seek_r ? (yv_r > val_q) : (yv_r < val_q);

  // Counters and control of the scan and walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      scan_vld_r <= 1'b0;
      first_r    <= 1'b0;
      bank_r     <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_step;
      if (cmd.clr_start || cmd.scan_start) begin
        cnt_r <= '0;
      end else if (cmd.clr_step || cmd.scan_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.scan_start) begin
        first_r <= 1'b1;
      end else if (scan_vld_r) begin
        first_r <= 1'b0;
      end
      if (cmd.bfs_init) begin
        bank_r <= 1'b0;
      end else if (cmd.lvl_accept) begin
        bank_r <= ~bank_r;
      end
    end
  end

  // Payload registers of the query.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cv_r <= in_tdata[9:0];
    end else if (cmd.q_cap) begin
      cv_r <= q_q;
    end
    if (cmd.deg_cap) begin
      deg_r <= deg_q;
      d_r   <= '0;
    end else if (cmd.d_inc) begin
      d_r <= d_r + DGW'(1);
    end
    if (cmd.nb_cap) begin
      nbv_r <= nb_q;
    end
    if (cmd.yv_cap) begin
      yv_r <= val_q;
    end
    // Running extremes over the scanned values.
    if (scan_vld_r) begin
      if (first_r || val_q < gmin_r) begin
        gmin_r <= val_q;
      end
      if (first_r || val_q > gmax_r) begin
        gmax_r <= val_q;
      end
    end
    // Level bookkeeping and density sums.
    if (cmd.bfs_init) begin
      cur_len_r <= CW'(1);
      hop_r     <= '0;
      last_ok_r <= '0;
      tot_r     <= '0;
      sat_r     <= '0;
    end else begin
      if (cmd.visit) begin
        tot_r <= tot_r + SUMW'(wt_q);
        if (worse_w) begin
          sat_r <= sat_r + SUMW'(wt_q);
        end
      end
      if (cmd.lvl_end) begin
        hop_r  <= hop_r + HOPW'(1);
        prod_r <= (THRW+SUMW)'(thr_r) * (THRW+SUMW)'(tot_r);
      end
      if (cmd.lvl_accept) begin
        last_ok_r <= hop_r;
        cur_len_r <= next_len_r;
      end
    end
    if (cmd.lvl_start) begin
      i_r        <= '0;
      next_len_r <= '0;
    end else begin
      if (cmd.q_cap) begin
        i_r <= i_r + CW'(1);
      end
      if (cmd.visit) begin
        next_len_r <= next_len_r + CW'(1);
      end
    end
  end

  // Pending result and output register.
  logic [RADW-1:0] res_rad_r, out_rad_r;
  status_t         res_stat_r, out_stat_r;
  logic            out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_stat_r <= cmd.res_status;
      case (cmd.res_sel)
        RS_NEG:  res_rad_r <= '1;
        RS_LAST: res_rad_r <= {1'b0, last_ok_r};
        default: res_rad_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_rad_r  <= res_rad_r;
      out_stat_r <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_stat_r, out_rad_r};

  // Status toward the controller.
  always_comb begin
    sts.mode      = mode_r;
    sts.idx_bad   = ({1'b0, vi_r} >= n_w) ||
                    ((mode_r == MODE_LINK) && ({1'b0, nbi_r} >= n_w));
    sts.deg_full  = (deg_r >= DGW'(ND));
    sts.clr_last  = (cnt_r == CW'(NV - 1));
    sts.scan_last = (cnt_r == n_w - CW'(1));
    sts.is_ext    = seek_r ? (yv_r == gmax_r) : (yv_r == gmin_r);
    sts.d_end     = (d_r >= deg_r);
    sts.nb_bad    = ({1'b0, nbv_r} >= n_w);
    sts.worse     = worse_w;
    sts.visited   = vis_q;
    sts.lvl_stop  = (cur_len_r == '0) || (hop_r >= hop_limit_r);
    sts.i_end     = (i_r >= cur_len_r);
    sts.tot_zero  = (tot_r == '0);
    sts.share_ok  = ((THRW+SUMW)'({sat_r, {FRACW{1'b0}}}) >= prod_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

/* hdl/gehr_chk.sv */
// Port checker of the hop radius engine and its bind to the top level.
`timescale 1ns / 1ps
module gehr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A result beat held back stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:11] != 2'd3)
    else $error("unused status code");

  // A failed item reports radius zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:11] != 2'd0 |-> out_tdata[10:0] == 11'd0)
    else $error("nonzero radius with error status");

  // The only negative radius is minus one.
  a_neg_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[10:0] == 11'h7FF)
    else $error("negative radius other than minus one");

  // Input is closed right after reset, as the clearing pass starts.
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open right after reset");

endmodule

bind graph_extremum_hop_radius gehr_chk u_gehr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/graph_extremum_hop_radius_test.sv */
// Self-checking testbench of the graph local-extremum hop radius engine.
`timescale 1ns / 1ps
module graph_extremum_hop_radius_test;
  import gehr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // mode
  logic [71:0] in_tdata;   // vertex_index, neighbor_index, sample_value, weight
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // radius, status

  graph_extremum_hop_radius DUT (.*);

  // One expected result beat.
  typedef struct {
    logic signed [RADW-1:0] radius;
    status_t                status;
  } radius_beat_t;

  radius_beat_t pending_radii[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           calm = 0;
  int           hold_asks = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  // Shadow copy of the engine's configuration and graph.
  logic [THRW-1:0]     thr_share;
  logic                hunt_max;
  logic [HOPW-1:0]     hop_cap;
  logic [CW-1:0]       used_vertices;
  logic signed [31:0]  vert_value [NV];
  logic [WTW-1:0]      vert_weight [NV];
  logic [VW-1:0]       adjacency [NV][ND];
  int                  fanout [NV];
  bit                  loaded [NV];

  // Clock and cycle limit.
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    radius_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_radii.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_radii.pop_front();
        if (out_tdata[10:0] !== want.radius) begin
          $display("%0t: radius expected %0d actual %0d", $time, want.radius,
                   $signed(out_tdata[10:0]));
          mismatches++;
        end
        if (out_tdata[12:11] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_tdata[12:11]);
          mismatches++;
        end
        if (out_tdata[15:13] !== 3'b0) begin
          $display("%0t: pad bits expected 0 actual %b", $time, out_tdata[15:13]);
          mismatches++;
        end
      end
    end
  end

  function automatic int vertex_limit();
    return (used_vertices > NV) ? NV : int'(used_vertices);
  endfunction

  function automatic bit beats(longint a, longint b);
    return hunt_max ? (a > b) : (a < b);
  endfunction

  // Hop radius of candidate v over the first n vertices.
  function automatic logic signed [RADW-1:0] hop_radius(int v, int n);
    longint            lo, hi, cand;
    longint unsigned   total, good;
    int                frontier[$], reached[$];
    bit                seen[NV];
    int                hop, last_ok, c, nb;
    lo = vert_value[0];
    hi = vert_value[0];
    cand = vert_value[v];
    for (int i = 1; i < n; i++) begin
      if (vert_value[i] < lo) lo = vert_value[i];
      if (vert_value[i] > hi) hi = vert_value[i];
    end
    if (hunt_max ? (cand == hi) : (cand == lo)) return RADW'(-1);
    for (int d = 0; d < fanout[v]; d++) begin
      nb = adjacency[v][d];
      if (nb < n && !beats(cand, vert_value[nb])) return '0;
    end
    seen[v] = 1;
    frontier.insert(frontier.size(), v);
    total = 0;
    good = 0;
    hop = 0;
    last_ok = 0;
    while (frontier.size() > 0 && hop < hop_cap) begin
      reached.delete();
      foreach (frontier[i]) begin
        c = frontier[i];
        for (int d = 0; d < fanout[c]; d++) begin
          nb = adjacency[c][d];
          if (nb >= n || seen[nb]) continue;
          seen[nb] = 1;
          reached.insert(reached.size(), nb);
          total += vert_weight[nb];
          if (beats(cand, vert_value[nb])) good += vert_weight[nb];
        end
      end
      hop++;
      if (total == 0) return RADW'(last_ok);
      if ((good << 16) >= longint'(thr_share) * total) last_ok = hop;
      else return RADW'(last_ok);
      frontier = reached;
    end
    return RADW'(last_ok);
  endfunction

  // Applies one input beat to the shadow graph and returns its result.
  function automatic radius_beat_t predict_beat(mode_t mode, int v, int nb,
                                                logic [31:0] val, logic [15:0] wt);
    radius_beat_t r;
    int n;
    n = vertex_limit();
    r.radius = 0;
    r.status = ST_OK;
    if (mode == MODE_CLEAR) begin
      foreach (fanout[i]) fanout[i] = 0;
    end else if (v >= n) begin
      r.status = ST_RANGE;
    end else if (mode == MODE_LOAD) begin
      vert_value[v] = val;
      vert_weight[v] = wt;
      loaded[v] = 1;
    end else if (mode == MODE_LINK) begin
      if (nb >= n) r.status = ST_RANGE;
      else if (fanout[v] >= ND) r.status = ST_FULL;
      else begin
        adjacency[v][fanout[v]] = nb;
        fanout[v]++;
      end
    end else begin
      r.radius = hop_radius(v, n);
    end
    return r;
  endfunction

  // Sends one beat; the checked result is either typed in or predicted.
  task automatic send_beat(mode_t mode, int v, int nb, logic [31:0] val,
                           logic [15:0] wt, bit typed = 0,
                           logic signed [RADW-1:0] t_rad = 0,
                           status_t t_st = ST_OK);
    radius_beat_t r;
    if (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, wt, val, nb[9:0], v[9:0]};
    do @(posedge clk); while (!in_tready);
    r = predict_beat(mode, v, nb, val, wt);
    if (typed) begin
      r.radius = t_rad;
      r.status = t_st;
    end
    pending_radii.insert(pending_radii.size(), r);
  endtask

  // Waits until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_radii.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THR:   thr_share = data;
      REG_SEEK:  hunt_max = data[0];
      REG_HOPS:  hop_cap = data[HOPW-1:0];
      REG_COUNT: used_vertices = data[CW-1:0];
      default: ;
    endcase
  endtask

  // Directed table: a register write or a beat with an optional typed result.
  typedef struct {
    bit                     is_reg;
    logic [1:0]             reg_idx;
    logic [16:0]            reg_data;
    mode_t                  mode;
    int                     v;
    int                     nb;
    logic [31:0]            val;
    logic [15:0]            wt;
    bit                     typed;
    logic signed [RADW-1:0] rad;
    status_t                st;
  } step_row_t;

  step_row_t steps[$];

  function automatic void reg_row(logic [1:0] idx, logic [16:0] data);
    step_row_t row;
    row = '{1, idx, data, MODE_LOAD, 0, 0, 0, 0, 0, 0, ST_OK};
    steps.insert(steps.size(), row);
  endfunction

  function automatic void beat_row(mode_t mode, int v, int nb, logic [31:0] val,
                                   logic [15:0] wt, bit typed = 0,
                                   logic signed [RADW-1:0] rad = 0,
                                   status_t st = ST_OK);
    step_row_t row;
    row = '{0, 0, 0, mode, v, nb, val, wt, typed, rad, st};
    steps.insert(steps.size(), row);
  endfunction

  function automatic int pick_vertex(int n);
    if (n > 0 && $urandom_range(99) < 88) return $urandom_range(n - 1);
    return $urandom_range(NV - 1);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 12) return $urandom;
    return $urandom_range(400) - 200;
  endfunction

  // Random phases: vertex count, seek sense, hop limit, threshold, items.
  typedef struct {
    int          count;
    bit          seek;
    int          hops;
    logic [16:0] thr;
    int          items;
  } phase_t;

  phase_t phases[$] = '{
    '{12, 1, 8, 17'd32768, 20},
    '{24, 0, 1023, 17'd65536, 20},
    '{1, 1, 8, 17'd1, 10},
    '{20, 1, 0, 17'd0, 15},
    '{0, 0, 5, 17'd131071, 8},
    '{40, 1, 3, 17'd0, 20},
    '{30, 0, 1023, 17'd49152, 20},
    '{48, 1, 1023, 17'd40000, 15},
    '{16, 0, 1, 17'd1, 20}
  };

  initial begin
    int n, v, c, kind, w, len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_THR;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = MODE_LOAD;
    in_tdata = '0;
    out_tready = 1'b0;
    thr_share = 17'd65536;
    hunt_max = 1'b1;
    hop_cap = 10'd8;
    used_vertices = 11'd1024;
    foreach (fanout[i]) begin
      fanout[i] = 0;
      loaded[i] = 0;
      vert_value[i] = 0;
      vert_weight[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, every mode and the special cases.
    beat_row(MODE_LOAD, 1023, 1023, 32'h7fff_ffff, 16'hffff, 1, 0, ST_OK);
    reg_row(REG_COUNT, 17'd8);
    beat_row(MODE_LOAD, 0, 0, 32'h7fff_ffff, 16'hffff, 1, 0, ST_OK);
    beat_row(MODE_LOAD, 1, 0, 32'h8000_0000, 16'h0000, 1, 0, ST_OK);
    for (int i = 2; i < 8; i++) beat_row(MODE_LOAD, i, 0, 10 * i, 16'(i));
    beat_row(MODE_QUERY, 0, 0, 0, 0, 1, -1, ST_OK);
    beat_row(MODE_QUERY, 9, 0, 0, 0, 1, 0, ST_RANGE);
    beat_row(MODE_LINK, 3, 8, 0, 0, 1, 0, ST_RANGE);
    beat_row(MODE_LINK, 3, 3, 0, 0, 1, 0, ST_OK);
    beat_row(MODE_QUERY, 3, 0, 0, 0, 1, 0, ST_OK);
    beat_row(MODE_LINK, 6, 5, 0, 0);
    beat_row(MODE_LINK, 5, 4, 0, 0);
    beat_row(MODE_LINK, 4, 2, 0, 0);
    beat_row(MODE_QUERY, 6, 0, 0, 0);
    reg_row(REG_SEEK, 17'd0);
    beat_row(MODE_QUERY, 1, 0, 0, 0, 1, -1, ST_OK);
    beat_row(MODE_QUERY, 2, 0, 0, 0);
    beat_row(MODE_CLEAR, 0, 0, 0, 0, 1, 0, ST_OK);
    reg_row(REG_COUNT, 17'd0);
    beat_row(MODE_QUERY, 0, 0, 0, 0, 1, 0, ST_RANGE);
    beat_row(MODE_LINK, 0, 0, 0, 0, 1, 0, ST_RANGE);
    foreach (steps[i]) begin
      if (steps[i].is_reg) write_reg(steps[i].reg_idx, steps[i].reg_data);
      else send_beat(steps[i].mode, steps[i].v, steps[i].nb, steps[i].val,
                     steps[i].wt, steps[i].typed, steps[i].rad, steps[i].st);
    end

    // Random part, one phase per register setting.
    foreach (phases[p]) begin
      write_reg(REG_THR, phases[p].thr);
      write_reg(REG_SEEK, 17'(phases[p].seek));
      write_reg(REG_HOPS, 17'(phases[p].hops));
      write_reg(REG_COUNT, 17'(phases[p].count));
      calm = (p == 1);
      n = vertex_limit();
      // Every vertex in use gets a value before any query reads it.
      for (int i = 0; i < n; i++)
        if (!loaded[i]) send_beat(MODE_LOAD, i, 0, pick_value(), 16'($urandom));
      if (n > 0) send_beat(MODE_CLEAR, 0, 0, 0, 0);
      if (p == 2) hold_asks++;
      for (int k = 0; k < phases[p].items; k++) begin
        kind = $urandom_range(99);
        v = pick_vertex(n);
        if (kind < 15) begin
          send_beat(MODE_LOAD, v, $urandom_range(NV - 1), pick_value(), 16'($urandom));
        end else if (kind < 42) begin
          send_beat(MODE_LINK, v, pick_vertex(n), 0, 0);
        end else if (kind < 68) begin
          send_beat(MODE_QUERY, v, $urandom_range(NV - 1), $urandom, 16'($urandom));
        end else if (kind < 72) begin
          send_beat(MODE_CLEAR, v, $urandom_range(NV - 1), $urandom, 16'($urandom));
        end else if (kind < 96 && n > 1) begin
          // Local peak with a small neighborhood, then a query on it.
          send_beat(MODE_LOAD, v, 0, $urandom_range(150, 190), 16'($urandom_range(1, 9)));
          len = $urandom_range(1, 4);
          for (int j = 0; j < len; j++) begin
            c = $urandom_range(n - 1);
            w = $urandom_range(99) < 15 ? 0 : $urandom;
            if (c != v) send_beat(MODE_LOAD, c, 0, $urandom_range(200) - 100, 16'(w));
            send_beat(MODE_LINK, v, c, 0, 0);
            send_beat(MODE_LINK, c, $urandom_range(n - 1), 0, 0);
          end
          send_beat(MODE_QUERY, v, 0, 0, 0);
        end else begin
          // Overfill one neighbor list.
          for (int j = 0; j < ND + 2; j++) send_beat(MODE_LINK, v, pick_vertex(n), 0, 0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
